FILE: rtl/bmr_pkg.sv
// Shared types and constants for the button mask remapper.
// Holds the rule layout, operation codes, register indexes and the
// command and status bundles between controller and datapath.
`default_nettype none

package bmr_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 34;
  localparam int MASK_W      = 16;
  localparam int FIRST_W     = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE0  = 3'd2;

  // Rule operation codes
  typedef enum logic [1:0] {
    OP_END   = 2'd0,
    OP_OR    = 2'd1,
    OP_SWAP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // One rule register: op in 33:32, mask B in 31:16, mask A in 15:0
  typedef struct packed {
    op_t               op;
    logic [MASK_W-1:0] mask_b;
    logic [MASK_W-1:0] mask_a;
  } rule_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // capture input words, start rule index at first_rule
    logic step;      // apply the current rule, advance the rule index
    logic load_out;  // copy working words into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_end;  // no further rule applies to the working words
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bmr_ctrl.sv
// Controller for the button mask remapper: sequences one item through
// input capture, the rule walk and the output register. Uses bmr_pkg.
`default_nettype none

module bmr_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire               m_tready,
  input  bmr_pkg::status_t  status,
  output bmr_pkg::cmd_t     cmd
);
  import bmr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Output register can take a result this cycle
  assign out_free = !m_tvalid || m_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_end) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs; hold off input transfers while in reset
  always_comb begin
    s_tready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = !rst;
        cmd.load_in = s_tvalid && !rst;
      end
      ST_WALK: begin
        cmd.step     = !status.walk_end;
        cmd.load_out = status.walk_end && out_free;
      end
      ST_HOLD: begin
        cmd.load_out = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Hold the result valid until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // An accepted item starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_WALK))
    else $error("accepted item did not start a walk");

  // Only one of step and load_out at a time
  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.load_out))
    else $error("step and load_out together");

endmodule

`default_nettype wire

FILE: rtl/bmr_dp.sv
// Datapath for the button mask remapper: configuration registers, rule
// index, working words with the shared rule unit, and the output register.
// Uses bmr_pkg.
`default_nettype none

module bmr_dp #(
  parameter int RULE_COUNT = 6,
  parameter int WORD_BITS  = 16,
  parameter int DATA_W     = 48
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [bmr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [bmr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire  [DATA_W-1:0]                   s_tdata,
  input  bmr_pkg::cmd_t                       cmd,
  output bmr_pkg::status_t                    status,
  output logic [DATA_W-1:0]                   m_tdata
);
  import bmr_pkg::*;

  localparam int NWORDS = 3;
  localparam int CW     = (WORD_BITS < MASK_W) ? WORD_BITS : MASK_W;

  logic                 remap_enable;
  logic [FIRST_W-1:0]   first_rule;
  rule_t                rules [RULE_COUNT];
  logic [FIRST_W-1:0]   rule_idx;
  rule_t                cur;
  logic [WORD_BITS-1:0] work     [NWORDS];
  logic [WORD_BITS-1:0] work_next[NWORDS];
  logic [WORD_BITS-1:0] result   [NWORDS];
  logic [WORD_BITS-1:0] ma_w;
  logic [WORD_BITS-1:0] mb_w;
  logic [WORD_BITS-1:0] keep_a;
  logic [WORD_BITS-1:0] keep_ab;
  logic [MASK_W-1:0]    inv_a;
  logic [MASK_W-1:0]    inv_ab;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      remap_enable <= 1'b0;
      first_rule   <= '0;
      for (int i = 0; i < RULE_COUNT; i++) begin
        rules[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: remap_enable <= cfg_data[0];
        REG_FIRST:  first_rule   <= cfg_data[FIRST_W-1:0];
        default: begin
          for (int i = 0; i < RULE_COUNT; i++) begin
            if (cfg_index == REG_RULE0 + CFG_INDEX_W'(i)) rules[i] <= rule_t'(cfg_data);
          end
        end
      endcase
    end
  end

  // Select the current rule; indexes past the table read as an end rule
  always_comb begin
    cur = '0;
    for (int i = 0; i < RULE_COUNT; i++) begin
      if (rule_idx == FIRST_W'(i)) cur = rules[i];
    end
  end

  assign status.walk_end = !remap_enable || (rule_idx >= FIRST_W'(RULE_COUNT)) ||
                           (cur.op == OP_END);

  // Masks at word width; complements are taken over 16 bits, then fitted
  assign inv_a   = ~cur.mask_a;
  assign inv_ab  = ~(cur.mask_a | cur.mask_b);
  assign ma_w    = WORD_BITS'(cur.mask_a[CW-1:0]);
  assign mb_w    = WORD_BITS'(cur.mask_b[CW-1:0]);
  assign keep_a  = WORD_BITS'(inv_a[CW-1:0]);
  assign keep_ab = WORD_BITS'(inv_ab[CW-1:0]);

  // Apply the current rule to each word independently
  always_comb begin
    for (int j = 0; j < NWORDS; j++) begin
      case (cur.op)
        OP_OR:    work_next[j] = ((work[j] & ma_w) != '0) ? (work[j] | mb_w) : work[j];
        OP_SWAP:  work_next[j] = (work[j] & keep_ab)
                               | (((work[j] & ma_w) != '0) ? mb_w : '0)
                               | (((work[j] & mb_w) != '0) ? ma_w : '0);
        OP_CLEAR: work_next[j] = work[j] & keep_a;
        default:  work_next[j] = work[j];
      endcase
    end
  end

  // Working words and rule index
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rule_idx <= first_rule;
      for (int j = 0; j < NWORDS; j++) begin
        work[j] <= s_tdata[j*WORD_BITS +: WORD_BITS];
      end
    end else if (cmd.step) begin
      rule_idx <= rule_idx + 1'b1;
      for (int j = 0; j < NWORDS; j++) begin
        work[j] <= work_next[j];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int j = 0; j < NWORDS; j++) begin
        result[j] <= work[j];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < NWORDS; j++) begin
      m_tdata[j*WORD_BITS +: WORD_BITS] = result[j];
    end
  end

  // A new walk starts at the configured first rule
  a_start_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (rule_idx == $past(first_rule)))
    else $error("walk did not start at first_rule");

  // Stepping only happens while a rule still applies
  a_step_live: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (remap_enable && cur.op != OP_END))
    else $error("step past end of walk");

endmodule

`default_nettype wire

FILE: rtl/button_mask_remapper_top.sv
// Button mask remapper top level: one rule per cycle over three words.
// An accepted item is captured, walked through the rules and copied into the output
// register; input is taken again only after that copy, and a result still waiting at
// walk end blocks input until it is taken. The rule table, first_rule and remap_enable
// set the walk length. Reset (rst, synchronous) clears all configuration registers to
// zero and empties the output register. Depends on bmr_pkg, bmr_ctrl, bmr_dp.
`default_nettype none

module button_mask_remapper_top #(
  parameter int RULE_COUNT = 6,
  parameter int WORD_BITS  = 16
) (
  input  wire                                            clk,
  input  wire                                            rst,
  // Input words
  input  wire                                            s_tvalid,
  output logic                                           s_tready,
  // word_zero_in, word_one_in, word_two_in from bit 0 up
  input  wire  [((3*WORD_BITS+7)/8)*8-1:0]               s_tdata,
  // Result words
  output logic                                           m_tvalid,
  input  wire                                            m_tready,
  // word_zero_out, word_one_out, word_two_out from bit 0 up
  output logic [((3*WORD_BITS+7)/8)*8-1:0]               m_tdata,
  // Configuration writes
  input  wire                                            cfg_valid,
  output logic                                           cfg_ready,
  input  wire  [bmr_pkg::CFG_INDEX_W-1:0]                cfg_index,
  input  wire  [bmr_pkg::CFG_DATA_W-1:0]                 cfg_data
);
  import bmr_pkg::*;

  localparam int DATA_W = ((3*WORD_BITS+7)/8)*8;

  cmd_t    cmd;
  status_t status;

  // Configuration transfers are taken whenever out of reset
  assign cfg_ready = !rst;

  bmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bmr_dp #(
    .RULE_COUNT (RULE_COUNT),
    .WORD_BITS  (WORD_BITS),
    .DATA_W     (DATA_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
